### sv/assert_macros.svh
// Assertion helpers used by distinct_window_max_sum.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on clk, switched off while rst_n is low.
`define DWMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same check with the clock and reset named by the caller.
`define DWMS_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error(msg);

`endif

### sv/dwms_pkg.sv
package dwms_pkg;

  // Sizing of the design
  localparam int WINDOW_MAX = 64;
  localparam int VALUE_BITS = 16;

  // Fixed field widths of the channels
  localparam int VALUE_W   = 16;
  localparam int SUM_W     = 22;
  localparam int CFG_LEN_W = 7;

  // Derived widths
  localparam int EFF_LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W     = $clog2(WINDOW_MAX + 2);
  localparam int POS_W     = 32;
  localparam int RAW_ACC_W = VALUE_BITS + $clog2(WINDOW_MAX);
  localparam int ACC_W     = (RAW_ACC_W > SUM_W) ? RAW_ACC_W : SUM_W;
  localparam int LEN_CMP_W = (CFG_LEN_W > EFF_LEN_W) ? CFG_LEN_W : EFF_LEN_W;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_LEN_W-1:0] WINDOW_LEN_RESET = CFG_LEN_W'(1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;
  } in_data_t;

  typedef struct packed {
    logic [SUM_W-1:0] window_sum;
    logic             window_ok;
    logic [SUM_W-1:0] best_sum;
  } out_data_t;

endpackage

### sv/dwms_ram.sv
// Simple dual-port RAM, registered read, write-first on a same-address hit.
module dwms_ram #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] byp_data_r;
  logic              byp_r;

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read and bypass data
  always_ff @(posedge clk) begin
    if (re) begin
      q_r        <= mem[raddr];
      byp_data_r <= wdata;
    end
  end

  // bypass flag: read and write hit the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (re) begin
      byp_r <= we && (waddr == raddr);
    end
  end

  assign rdata = byp_r ? byp_data_r : q_r;

endmodule

### sv/dwms_regs.sv
// Configuration registers behind the APB-style port.
module dwms_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dwms_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dwms_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dwms_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [dwms_pkg::EFF_LEN_W-1:0]      eff_len
);

  logic [dwms_pkg::CFG_LEN_W-1:0] win_len_r;
  logic [dwms_pkg::LEN_CMP_W-1:0] len_ext;
  logic                           sel_len;

  assign sel_len = (paddr[2] == dwms_pkg::REG_WINDOW_LEN);
  assign pready  = 1'b1;

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= dwms_pkg::WINDOW_LEN_RESET;
    end else if (psel && penable && pwrite && sel_len) begin
      win_len_r <= pwdata[dwms_pkg::CFG_LEN_W-1:0];
    end
  end

  assign prdata = sel_len ? dwms_pkg::CFG_DATA_W'(win_len_r) : '0;

  // length in force: zero acts as one, oversize clamps to the window depth
  assign len_ext = dwms_pkg::LEN_CMP_W'(win_len_r);

  always_comb begin
    priority if (len_ext == '0) begin
      eff_len = dwms_pkg::EFF_LEN_W'(1);
    end else if (len_ext > dwms_pkg::LEN_CMP_W'(dwms_pkg::WINDOW_MAX)) begin
      eff_len = dwms_pkg::EFF_LEN_W'(dwms_pkg::WINDOW_MAX);
    end else begin
      eff_len = dwms_pkg::EFF_LEN_W'(len_ext);
    end
  end

endmodule

### sv/distinct_window_max_sum.sv
// Best window sum over full windows of distinct values.
//
// Input channel (in_valid / in_stall / in_data): one value per transaction;
// in_data.first opens a new sequence. Result channel (out_valid / out_stall /
// out_data): exactly one result per input transaction, in order, holding the
// sum of the last window_len values, the qualify flag and the best
// qualifying sum of the sequence so far.
// Configuration: window_len at byte address 0 of the cfg_ port; write it
// only while no transaction is in flight.
// A result passes through stage 1, stage 2 and the output register; throughput
// is one transaction per cycle while in_stall is low. Each transaction does one
// read-modify-write of the last-seen table and one read and one write of the
// prefix-sum ring, both bypassed on back-to-back hits.
// After reset the last-seen table (65536 entries) is swept to zero with
// in_stall high; the first sequence then starts with the next
// transaction. When the receiver stalls, the result holds and the pipeline
// keeps accepting until its three stages are full.
`include "assert_macros.svh"

module distinct_window_max_sum (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dwms_pkg::in_data_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dwms_pkg::out_data_t                out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dwms_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dwms_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dwms_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int VB    = dwms_pkg::VALUE_BITS;
  localparam int PTR_W = dwms_pkg::PTR_W;
  localparam int CNT_W = dwms_pkg::CNT_W;
  localparam int POS_W = dwms_pkg::POS_W;
  localparam int ACC_W = dwms_pkg::ACC_W;
  localparam int LW    = dwms_pkg::EFF_LEN_W;

  logic [LW-1:0] eff_len;

  // stage enables
  logic en_out, en_s2, s1_go, acc;

  // accept stage state
  logic             clr_r;
  logic [VB-1:0]    clr_cnt_r;
  logic [POS_W-1:0] idx_r, seq_start_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] ptr_r;

  // accept stage logic
  logic [VB-1:0]    v_in;
  logic [CNT_W-1:0] cnt_base, cnt_item, len_c;
  logic [POS_W-1:0] sstart, tag_in;
  logic [LW-1:0]    ptr_ext;
  logic [PTR_W-1:0] ring_raddr, ptr_next;

  // stage 1
  logic             s1_valid_r, s1_first_r, s1_full_r, s1_sub_r;
  logic [VB-1:0]    s1_v_r;
  logic [POS_W-1:0] s1_tag_r, s1_sstart_r, s1_thr_r;
  logic [PTR_W-1:0] s1_ptr_r;
  logic [POS_W-1:0] seen_q, latest_r, latest_base, latest_new;
  logic [ACC_W-1:0] ring_q, p_r, p_new, sub_val;
  logic             in_seq, s1_ok;

  // stage 2
  logic             s2_valid_r, s2_first_r, s2_ok_r;
  logic [ACC_W-1:0] s2_p_r, s2_sub_r;
  logic [ACC_W-1:0] best_r, sum, best_base, best_new;

  // output register
  logic                out_valid_r;
  dwms_pkg::out_data_t out_data_r;

  // seen table write port, shared with the clearing sweep
  logic             seen_we;
  logic [VB-1:0]    seen_waddr;
  logic [POS_W-1:0] seen_wdata;

  dwms_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .eff_len (eff_len)
  );

  // pipeline flow
  assign en_out   = !out_valid_r || !out_stall;
  assign en_s2    = !s2_valid_r || en_out;
  assign s1_go    = s1_valid_r && en_s2;
  assign in_stall = clr_r || (s1_valid_r && !en_s2);
  assign acc      = in_valid && !in_stall;

  // accept stage: per-transaction position, count and ring address
  always_comb begin
    v_in     = VB'(in_data.value);
    cnt_base = in_data.first ? '0 : cnt_r;
    cnt_item = (cnt_base == CNT_W'(dwms_pkg::WINDOW_MAX + 1)) ? cnt_base
                                                               : cnt_base + CNT_W'(1);
    len_c    = CNT_W'(eff_len);
    sstart   = in_data.first ? idx_r : seq_start_r;
    tag_in   = idx_r + POS_W'(1);
    ptr_ext  = LW'(ptr_r);
    if (ptr_ext >= eff_len) begin
      ring_raddr = PTR_W'(ptr_ext - eff_len);
    end else begin
      ring_raddr = PTR_W'(ptr_ext + LW'(dwms_pkg::WINDOW_MAX) - eff_len);
    end
    ptr_next = (ptr_r == PTR_W'(dwms_pkg::WINDOW_MAX - 1)) ? '0 : ptr_r + PTR_W'(1);
  end

  // accept stage counters and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      idx_r       <= '0;
      seq_start_r <= '0;
      cnt_r       <= '0;
      ptr_r       <= '0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + VB'(1);
        if (&clr_cnt_r) begin
          clr_r <= 1'b0;
        end
      end
      if (acc) begin
        idx_r       <= tag_in;
        seq_start_r <= sstart;
        cnt_r       <= cnt_item;
        ptr_r       <= ptr_next;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_first_r  <= in_data.first;
      s1_v_r      <= v_in;
      s1_tag_r    <= tag_in;
      s1_sstart_r <= sstart;
      s1_thr_r    <= tag_in - POS_W'(eff_len);
      s1_full_r   <= cnt_item >= len_c;
      s1_sub_r    <= cnt_item > len_c;
      s1_ptr_r    <= ptr_r;
    end
  end

  // last-seen table: tag of the latest transaction that carried each value
  assign seen_we    = clr_r || s1_go;
  assign seen_waddr = clr_r ? clr_cnt_r : s1_v_r;
  assign seen_wdata = clr_r ? '0 : s1_tag_r;

  dwms_ram #(
    .DEPTH  (1 << VB),
    .DATA_W (POS_W)
  ) u_seen_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (acc),
    .raddr (v_in),
    .rdata (seen_q)
  );

  // prefix-sum ring, one entry per recent transaction
  dwms_ram #(
    .DEPTH  (dwms_pkg::WINDOW_MAX),
    .DATA_W (ACC_W)
  ) u_ring_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (s1_go),
    .waddr (s1_ptr_r),
    .wdata (p_new),
    .re    (acc),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  // stage 1: repeat tracking and prefix update
  always_comb begin
    latest_base = s1_first_r ? '0 : latest_r;
    in_seq      = seen_q > s1_sstart_r;
    latest_new  = (in_seq && (seen_q > latest_base)) ? seen_q : latest_base;
    s1_ok       = s1_full_r && (latest_base <= s1_thr_r) && (!in_seq || (seen_q <= s1_thr_r));
    p_new       = (s1_first_r ? '0 : p_r) + ACC_W'(s1_v_r);
    sub_val     = s1_sub_r ? ring_q : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      latest_r   <= '0;
      p_r        <= '0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (en_s2) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        latest_r <= latest_new;
        p_r      <= p_new;
      end
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_first_r <= s1_first_r;
      s2_ok_r    <= s1_ok;
      s2_p_r     <= p_new;
      s2_sub_r   <= sub_val;
    end
  end

  // stage 2: window sum and best so far
  always_comb begin
    sum       = s2_p_r - s2_sub_r;
    best_base = s2_first_r ? '0 : best_r;
    best_new  = (s2_ok_r && (sum > best_base)) ? sum : best_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      best_r      <= '0;
    end else begin
      if (en_s2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s2_valid_r;
        if (s2_valid_r) begin
          best_r <= best_new;
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (en_out && s2_valid_r) begin
      out_data_r.window_sum <= dwms_pkg::SUM_W'(sum);
      out_data_r.window_ok  <= s2_ok_r;
      out_data_r.best_sum   <= dwms_pkg::SUM_W'(best_new);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `DWMS_ASSERT(a_no_item_in_clear, clr_r |-> (!s1_valid_r && !s2_valid_r),
               "transaction in flight during table clear")
  `DWMS_ASSERT(a_clear_complete, $fell(clr_r) |-> &($past(clr_cnt_r)),
               "table clear ended early")
  `DWMS_ASSERT(a_accept_fills_s1, (in_valid && !in_stall) |=> s1_valid_r,
               "accepted transaction lost before stage 1")
  `DWMS_ASSERT(a_best_covers_ok,
               (out_valid_r && out_data_r.window_ok) |->
                 (out_data_r.best_sum >= out_data_r.window_sum),
               "best sum below a qualifying window sum")

endmodule
